FILE: rtl/crt_pkg.sv
package crt_pkg;

    localparam int MODULUS_BITS_DEF = 16;
    localparam int YEAR_BITS        = 32;

endpackage

FILE: rtl/crt_div.sv
module crt_div
    import crt_pkg::*;
#(
    parameter int WIDTH = MODULUS_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             done,
    output logic [WIDTH-1:0] quo,
    output logic [WIDTH-1:0] rem
);

    localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

    logic             busy_reg;
    logic             done_reg;
    logic [CW-1:0]    cnt_reg;
    logic [WIDTH-1:0] rem_reg;
    logic [WIDTH-1:0] quo_reg;
    logic [WIDTH-1:0] dsr_reg;

    logic [WIDTH:0]   partial;
    logic [WIDTH:0]   diff;
    logic             ge;
    logic [WIDTH-1:0] rem_next;
    logic [WIDTH-1:0] quo_next;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        partial  = {rem_reg, quo_reg[WIDTH-1]};
        diff     = partial - {1'b0, dsr_reg};
        ge       = (partial >= {1'b0, dsr_reg});
        rem_next = ge ? diff[WIDTH-1:0] : partial[WIDTH-1:0];
        quo_next = {quo_reg[WIDTH-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                rem_reg  <= '0;
                quo_reg  <= dividend;
                dsr_reg  <= divisor;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_next;
                quo_reg <= quo_next;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(WIDTH - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;
    assign rem  = rem_reg;

endmodule

FILE: rtl/crt_pair_search_top.sv
// channel   signals                                          transfer when
// input     start, modulus_m, modulus_n, residue_x, residue_y  start && !busy
// result    done, year, found                                done (one cycle)
//
// one item runs the input checks, one division per euclid step of the gcd,
// three more divisions and one multiply, then the search over candidates
// (at most n/gcd(m,n)+1 candidates); all divisions use the shared restoring
// divider, and the search loop tests one candidate per cycle
// reset is asynchronous active low and returns the sequencer to idle
// results cannot be stalled; busy stays high from accept until done, but an item rejected at accept never raises it
module crt_pair_search_top
    import crt_pkg::*;
#(
    parameter int MODULUS_BITS = MODULUS_BITS_DEF
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [MODULUS_BITS-1:0] modulus_m,
    input  logic [MODULUS_BITS-1:0] modulus_n,
    input  logic [MODULUS_BITS-1:0] residue_x,
    input  logic [MODULUS_BITS-1:0] residue_y,
    output logic                    done,
    output logic [YEAR_BITS-1:0]    year,
    output logic                    found
);

    localparam int MB = MODULUS_BITS;
    localparam int LW = 2 * MB;
    localparam int KW = 2 * MB + 1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GCD,
        S_GCD_WAIT,
        S_LIM_WAIT,
        S_MUL,
        S_CHK,
        S_MODX_WAIT,
        S_MODM_WAIT,
        S_SEARCH
    } state_t;

    state_t          state_reg;
    logic [MB-1:0]   m_reg;
    logic [MB-1:0]   n_reg;
    logic [MB-1:0]   x_reg;
    logic [MB-1:0]   y_reg;
    logic [MB-1:0]   p_reg;
    logic [MB-1:0]   q_reg;
    logic [MB-1:0]   lq_reg;
    logic [LW-1:0]   limit_reg;
    logic [KW-1:0]   k_reg;
    logic [MB-1:0]   r_reg;
    logic [MB-1:0]   step_reg;
    logic            div_go_reg;
    logic [MB-1:0]   div_a_reg;
    logic [MB-1:0]   div_b_reg;
    logic            done_reg;
    logic            found_reg;
    logic [YEAR_BITS-1:0] year_reg;

    logic            div_done;
    logic [MB-1:0]   div_quo;
    logic [MB-1:0]   div_rem;

    logic [KW-1:0]   k_next;
    logic [MB:0]     r_sum;
    logic [MB-1:0]   r_next;

    crt_div #(
        .WIDTH (MB)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (div_go_reg),
        .dividend (div_a_reg),
        .divisor  (div_b_reg),
        .done     (div_done),
        .quo      (div_quo),
        .rem      (div_rem)
    );

    always_comb
    begin
        k_next = k_reg + KW'(m_reg);
        r_sum  = {1'b0, r_reg} + {1'b0, step_reg};
        if (r_sum >= {1'b0, n_reg})
            r_next = MB'(r_sum - {1'b0, n_reg});
        else
            r_next = r_sum[MB-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            div_go_reg <= 1'b0;
            done_reg   <= 1'b0;
            found_reg  <= 1'b0;
        end
        else
        begin
            div_go_reg <= 1'b0;
            done_reg   <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        m_reg <= modulus_m;
                        n_reg <= modulus_n;
                        x_reg <= residue_x;
                        y_reg <= (residue_y == modulus_n) ? '0 : residue_y;
                        if (modulus_m >= modulus_n)
                        begin
                            p_reg <= modulus_m;
                            q_reg <= modulus_n;
                        end
                        else
                        begin
                            p_reg <= modulus_n;
                            q_reg <= modulus_m;
                        end
                        // zero modulus or residue_y above modulus_n: no match possible
                        if (modulus_m == '0 || modulus_n == '0 || residue_y > modulus_n)
                        begin
                            done_reg  <= 1'b1;
                            found_reg <= 1'b0;
                            year_reg  <= '0;
                        end
                        else
                            state_reg <= S_GCD;
                    end
                end
                S_GCD:
                begin
                    div_go_reg <= 1'b1;
                    if (q_reg == '0)
                    begin
                        div_a_reg <= m_reg;
                        div_b_reg <= p_reg;
                        state_reg <= S_LIM_WAIT;
                    end
                    else
                    begin
                        div_a_reg <= p_reg;
                        div_b_reg <= q_reg;
                        state_reg <= S_GCD_WAIT;
                    end
                end
                S_GCD_WAIT:
                begin
                    if (div_done)
                    begin
                        p_reg     <= q_reg;
                        q_reg     <= div_rem;
                        state_reg <= S_GCD;
                    end
                end
                S_LIM_WAIT:
                begin
                    if (div_done)
                    begin
                        lq_reg    <= div_quo;
                        state_reg <= S_MUL;
                    end
                end
                S_MUL:
                begin
                    limit_reg <= LW'(lq_reg) * LW'(n_reg);
                    state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    k_reg <= KW'(x_reg);
                    if (LW'(x_reg) > limit_reg)
                    begin
                        done_reg  <= 1'b1;
                        found_reg <= 1'b0;
                        year_reg  <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        div_go_reg <= 1'b1;
                        div_a_reg  <= x_reg;
                        div_b_reg  <= n_reg;
                        state_reg  <= S_MODX_WAIT;
                    end
                end
                S_MODX_WAIT:
                begin
                    if (div_done)
                    begin
                        r_reg      <= div_rem;
                        div_go_reg <= 1'b1;
                        div_a_reg  <= m_reg;
                        div_b_reg  <= n_reg;
                        state_reg  <= S_MODM_WAIT;
                    end
                end
                S_MODM_WAIT:
                begin
                    if (div_done)
                    begin
                        step_reg  <= div_rem;
                        state_reg <= S_SEARCH;
                    end
                end
                S_SEARCH:
                begin
                    if (r_reg == y_reg)
                    begin
                        done_reg  <= 1'b1;
                        found_reg <= 1'b1;
                        year_reg  <= YEAR_BITS'(k_reg);
                        state_reg <= S_IDLE;
                    end
                    else if (k_next > KW'(limit_reg))
                    begin
                        done_reg  <= 1'b1;
                        found_reg <= 1'b0;
                        year_reg  <= '0;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        k_reg <= k_next;
                        r_reg <= r_next;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy  = (state_reg != S_IDLE);
    assign done  = done_reg;
    assign found = found_reg;
    assign year  = year_reg;

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("accepted item neither busy nor finished");

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (year == '0))
        else $error("miss with nonzero year");

    a_residue_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SEARCH) |-> (r_reg < n_reg))
        else $error("running residue out of range");

endmodule
